// ----- hw/rtl/but_pkg.sv -----
`timescale 1ns / 1ps

package but_pkg;

	// Width of the counter and reload registers unless overridden at the top level.
	localparam int DEFAULT_COUNT_WIDTH = 16;

	// Item kinds carried in the mode field.
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// Register map.
	localparam logic [2:0] ADDR_CTRL  = 3'd0;
	localparam logic [2:0] ADDR_IRQEN = 3'd1;
	localparam logic [2:0] ADDR_STAT  = 3'd2;
	localparam logic [2:0] ADDR_EVENT = 3'd3;
	localparam logic [2:0] ADDR_CNT   = 3'd4;
	localparam logic [2:0] ADDR_PSC   = 3'd5;
	localparam logic [2:0] ADDR_ARR   = 3'd6;

	// Bit positions inside the control, event and status registers.
	localparam int CTRL_CEN_BIT  = 0;
	localparam int CTRL_UDIS_BIT = 1;
	localparam int CTRL_URS_BIT  = 2;
	localparam int CTRL_OPM_BIT  = 3;
	localparam int CTRL_ARPE_BIT = 7;
	localparam int EVENT_UG_BIT  = 0;
	localparam int STAT_UIF_BIT  = 0;
	localparam int IRQEN_UIE_BIT = 0;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  reg_addr;
		logic [15:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        update_event;
		logic        irq;
	} out_item_t;

endpackage

// ----- hw/rtl/basic_update_timer_unit.sv -----
`timescale 1ns / 1ps

// The result of an accepted item is registered in the output or the skid register.
// Throughput: one item per cycle unless stalled; each item is fully resolved on accept.
// An output register plus a one-entry skid register keep input accepted while a result
// waits, so input stalls only after two results are held back by the consumer.
// Reset (arst_n low, asynchronous): counter, prescaler, flags and control clear, reload
// preload and active reload go to all ones, and no result is pending.
module basic_update_timer_unit #(
	parameter int COUNT_WIDTH = but_pkg::DEFAULT_COUNT_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  but_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output but_pkg::out_item_t out_item
);

	import but_pkg::*;

	// Architectural timer state. These registers are the whole state of the timer; every
	// accepted item reads them and writes their next values in the same cycle.
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n;
	logic [15:0]            psc_q, psc_n;
	logic [15:0]            psc_pre_q, psc_pre_n;
	logic [15:0]            psc_act_q, psc_act_n;
	logic [COUNT_WIDTH-1:0] arr_pre_q, arr_pre_n;
	logic [COUNT_WIDTH-1:0] arr_act_q, arr_act_n;
	logic                   cen_q, cen_n;
	logic                   udis_q, udis_n;
	logic                   urs_q, urs_n;
	logic                   opm_q, opm_n;
	logic                   arpe_q, arpe_n;
	logic                   uie_q, uie_n;
	logic                   uif_q, uif_n;

	// Result path: an output register and a skid register behind it.
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      skid_valid_q;
	out_item_t skid_item_q;

	logic      accept;
	logic      out_free;
	out_item_t result;
	logic [COUNT_WIDTH-1:0] wr_count;

	function automatic logic [31:0] write_data_ext(input logic [15:0] d);
		write_data_ext = {16'd0, d};
	endfunction

	// The skid register is the only thing that can push back on the input.
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Counter and reload writes keep the low COUNT_WIDTH bits of the 16-bit data.
	assign wr_count = COUNT_WIDTH'(write_data_ext(in_item.write_data));

	// Next-state and result logic for one item.
	always_comb begin
		cnt_n     = cnt_q;
		psc_n     = psc_q;
		psc_pre_n = psc_pre_q;
		psc_act_n = psc_act_q;
		arr_pre_n = arr_pre_q;
		arr_act_n = arr_act_q;
		cen_n     = cen_q;
		udis_n    = udis_q;
		urs_n     = urs_q;
		opm_n     = opm_q;
		arpe_n    = arpe_q;
		uie_n     = uie_q;
		uif_n     = uif_q;
		result    = '0;

		case (in_item.mode)
			MODE_TICK: begin
				// Ticks count only while the counter is enabled.
				if (cen_q) begin
					if (psc_q >= psc_act_q) begin
						// Prescaler wrap: the counter advances by one. A zero reload
						// freezes the counter.
						psc_n = '0;
						if (arr_act_q != '0) begin
							if (cnt_q == arr_act_q) begin
								// Overflow: wrap, and unless updates are disabled load the
								// shadow registers, set the flag and stop in one-pulse mode.
								cnt_n = '0;
								if (!udis_q) begin
									psc_act_n           = psc_pre_q;
									arr_act_n           = arr_pre_q;
									uif_n               = 1'b1;
									result.update_event = 1'b1;
									if (opm_q) begin
										cen_n = 1'b0;
									end
								end
							end else begin
								// A counter above the reload wraps silently at its maximum.
								cnt_n = cnt_q + COUNT_WIDTH'(1);
							end
						end
					end else begin
						psc_n = psc_q + 16'd1;
					end
				end
			end
			MODE_WRITE: begin
				case (in_item.reg_addr)
					ADDR_CTRL: begin
						cen_n  = in_item.write_data[CTRL_CEN_BIT];
						udis_n = in_item.write_data[CTRL_UDIS_BIT];
						urs_n  = in_item.write_data[CTRL_URS_BIT];
						opm_n  = in_item.write_data[CTRL_OPM_BIT];
						arpe_n = in_item.write_data[CTRL_ARPE_BIT];
					end
					ADDR_IRQEN: begin
						uie_n = in_item.write_data[IRQEN_UIE_BIT];
					end
					ADDR_STAT: begin
						// Writing zero clears the flag; writing one leaves it.
						uif_n = uif_q & in_item.write_data[STAT_UIF_BIT];
					end
					ADDR_EVENT: begin
						// A forced update restarts counting and, unless updates are
						// disabled, loads the shadows. The update request source bit
						// keeps it from setting the flag.
						if (in_item.write_data[EVENT_UG_BIT]) begin
							cnt_n = '0;
							psc_n = '0;
							if (!udis_q) begin
								psc_act_n           = psc_pre_q;
								arr_act_n           = arr_pre_q;
								result.update_event = 1'b1;
								if (!urs_q) begin
									uif_n = 1'b1;
								end
							end
						end
					end
					ADDR_CNT: begin
						cnt_n = wr_count;
					end
					ADDR_PSC: begin
						psc_pre_n = in_item.write_data;
					end
					ADDR_ARR: begin
						// Without reload preload the new value takes effect at once.
						arr_pre_n = wr_count;
						if (!arpe_q) begin
							arr_act_n = wr_count;
						end
					end
					default: begin
					end
				endcase
			end
			MODE_READ: begin
				case (in_item.reg_addr)
					ADDR_CTRL: begin
						result.read_data[CTRL_CEN_BIT]  = cen_q;
						result.read_data[CTRL_UDIS_BIT] = udis_q;
						result.read_data[CTRL_URS_BIT]  = urs_q;
						result.read_data[CTRL_OPM_BIT]  = opm_q;
						result.read_data[CTRL_ARPE_BIT] = arpe_q;
					end
					ADDR_IRQEN: begin
						result.read_data[IRQEN_UIE_BIT] = uie_q;
					end
					ADDR_STAT: begin
						result.read_data[STAT_UIF_BIT] = uif_q;
					end
					ADDR_CNT: begin
						result.read_data = 16'(cnt_q);
					end
					ADDR_PSC: begin
						result.read_data = psc_pre_q;
					end
					ADDR_ARR: begin
						result.read_data = 16'(arr_pre_q);
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		// The interrupt request reflects the state after this item.
		result.irq = uif_n & uie_n;
	end

	// Timer state updates only on accepted items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			psc_q     <= '0;
			psc_pre_q <= '0;
			psc_act_q <= '0;
			arr_pre_q <= '1;
			arr_act_q <= '1;
			cen_q     <= 1'b0;
			udis_q    <= 1'b0;
			urs_q     <= 1'b0;
			opm_q     <= 1'b0;
			arpe_q    <= 1'b0;
			uie_q     <= 1'b0;
			uif_q     <= 1'b0;
		end else if (accept) begin
			cnt_q     <= cnt_n;
			psc_q     <= psc_n;
			psc_pre_q <= psc_pre_n;
			psc_act_q <= psc_act_n;
			arr_pre_q <= arr_pre_n;
			arr_act_q <= arr_act_n;
			cen_q     <= cen_n;
			udis_q    <= udis_n;
			urs_q     <= urs_n;
			opm_q     <= opm_n;
			arpe_q    <= arpe_n;
			uie_q     <= uie_n;
			uif_q     <= uif_n;
		end
	end

	// Result valid bits. When the output register frees up it takes the skid entry first,
	// which keeps results in order. The input is stalled while the skid entry is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payloads.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_item_q <= skid_item_q;
			end else if (accept) begin
				out_item_q <= result;
			end
		end else if (accept) begin
			skid_item_q <= result;
		end
	end

endmodule

// ----- sim/tb_basic_update_timer_unit.sv -----
`timescale 1ns / 1ps

module tb_basic_update_timer_unit;

	import but_pkg::*;

	// Codes that the package leaves unnamed: the spare mode and the spare register address.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [2:0] ADDR_SPARE = 3'd7;

	// Generous cycle budget: about a thousand items, each possibly held up by a sender gap,
	// a receiver stall and the one long receiver hold-off, taken many times over.
	localparam int CYCLE_LIMIT = 200000;

	// The receiver holds off once for this many cycles, after this many items went in.
	localparam int HOLD_CYCLES = 64;
	localparam int HOLD_AT_ITEM = 400;

	// Once fewer items than this are left to send, neither side idles any more.
	localparam int CALM_TAIL = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	basic_update_timer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	always #2 clk = ~clk;

	// Items waiting to be offered, and the results the timer owes us, oldest first.
	in_item_t  pending_items[$];
	out_item_t owed_results[$];

	int items_in = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cycle_cnt = 0;

	// Our own copy of the timer: counter, prescaler, the preload and active (shadow) copies
	// of prescaler and reload, control bits, interrupt enable and the update flag.
	logic [15:0] cnt_q, psc_cnt, psc_pre, psc_act, arr_pre, arr_act;
	logic        cen, udis, urs, opm, arpe, uie, uif;

	wire calm = (pending_items.size() < CALM_TAIL);

	// Applies one item to the timer copy and returns the result the block must give for it.
	task automatic timer_step(input in_item_t it, output out_item_t res);
		logic        ev;
		logic [15:0] rd;
		ev = 1'b0;
		rd = '0;
		case (it.mode)
			MODE_TICK: begin
				// Disabled ticks change nothing at all.
				if (cen) begin
					if (psc_cnt >= psc_act) begin
						psc_cnt = '0;
						// With an active reload of zero the counter is frozen.
						if (arr_act != '0) begin
							if (cnt_q == arr_act) begin
								// Overflow. With updates disabled it only wraps to zero.
								cnt_q = '0;
								if (!udis) begin
									psc_act = psc_pre;
									arr_act = arr_pre;
									uif = 1'b1;
									if (opm)
										cen = 1'b0;
									ev = 1'b1;
								end
							end else begin
								// A counter above the reload wraps silently past its top.
								cnt_q = cnt_q + 16'd1;
							end
						end
					end else begin
						psc_cnt = psc_cnt + 16'd1;
					end
				end
			end
			MODE_WRITE: begin
				case (it.reg_addr)
					ADDR_CTRL: begin
						cen  = it.write_data[CTRL_CEN_BIT];
						udis = it.write_data[CTRL_UDIS_BIT];
						urs  = it.write_data[CTRL_URS_BIT];
						opm  = it.write_data[CTRL_OPM_BIT];
						arpe = it.write_data[CTRL_ARPE_BIT];
					end
					ADDR_IRQEN: uie = it.write_data[IRQEN_UIE_BIT];
					// The flag is write-zero-to-clear; a one leaves it alone.
					ADDR_STAT: uif = uif & it.write_data[STAT_UIF_BIT];
					ADDR_EVENT: begin
						// A forced update always clears both counts, but only reloads the
						// shadows and reports an event while updates are enabled.
						if (it.write_data[EVENT_UG_BIT]) begin
							cnt_q = '0;
							psc_cnt = '0;
							if (!udis) begin
								psc_act = psc_pre;
								arr_act = arr_pre;
								if (!urs)
									uif = 1'b1;
								ev = 1'b1;
							end
						end
					end
					ADDR_CNT: cnt_q = it.write_data;
					ADDR_PSC: psc_pre = it.write_data;
					ADDR_ARR: begin
						arr_pre = it.write_data;
						// Without reload preload the new value takes effect at once.
						if (!arpe)
							arr_act = it.write_data;
					end
					default: ;
				endcase
			end
			MODE_READ: begin
				case (it.reg_addr)
					ADDR_CTRL: begin
						rd[CTRL_CEN_BIT]  = cen;
						rd[CTRL_UDIS_BIT] = udis;
						rd[CTRL_URS_BIT]  = urs;
						rd[CTRL_OPM_BIT]  = opm;
						rd[CTRL_ARPE_BIT] = arpe;
					end
					ADDR_IRQEN: rd[IRQEN_UIE_BIT] = uie;
					ADDR_STAT: rd[STAT_UIF_BIT] = uif;
					ADDR_CNT: rd = cnt_q;
					ADDR_PSC: rd = psc_pre;
					ADDR_ARR: rd = arr_pre;
					// The event register and the spare address read as zero.
					default: rd = '0;
				endcase
			end
			default: ;
		endcase
		res.read_data = rd;
		res.update_event = ev;
		res.irq = uif & uie;
	endtask

	task automatic queue_item(input logic [1:0] m, input logic [2:0] a, input logic [15:0] d);
		in_item_t it;
		it.mode = m;
		it.reg_addr = a;
		it.write_data = d;
		pending_items.push_back(it);
	endtask

	// Sender. An item is taken at an edge where valid is high and stall is low; at that edge
	// the prediction for it is made. A stalled item is held unchanged. When the sender is free
	// it may start an idle burst, but only in alternate stretches of 128 items,
	// so that long runs without gaps occur as well.
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			gap_left = 0;
			cnt_q = '0;
			psc_cnt = '0;
			psc_pre = '0;
			psc_act = '0;
			arr_pre = '1;
			arr_act = '1;
			{cen, udis, urs, opm, arpe, uie, uif} = '0;
		end else begin : sender
			out_item_t res;
			if (in_valid && !in_stall) begin
				timer_step(in_item, res);
				owed_results.push_back(res);
				items_in++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!calm && items_in[7] && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(0, 5);
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					in_item <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The one long hold-off of the receiver, counted here. The sender keeps offering while it
	// lasts, so the output and skid registers fill and the block must stall its input.
	int  hold_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && items_in >= HOLD_AT_ITEM) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver stall: random bursts in alternate stretches of 64 results,
	// none in the tail, and held high for the whole hold-off.
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && results_seen[6] && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= (hold_left != 0);
		end
	end

	// Monitor. Each result taken is compared field by field with the oldest one owed.
	always @(posedge clk) begin : result_monitor
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (owed_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with none owed: read_data %h update_event %b irq %b",
						$realtime, out_item.read_data, out_item.update_event, out_item.irq);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				if (out_item.read_data !== want.read_data ||
					out_item.update_event !== want.update_event ||
					out_item.irq !== want.irq) begin
					if (mismatches < 10)
						$display("%0t: result %0d: expected read_data %h update_event %b irq %b, got %h %b %b",
							$realtime, results_seen, want.read_data, want.update_event, want.irq,
							out_item.read_data, out_item.update_event, out_item.irq);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_basic_update_timer_unit: FAIL");
			$finish;
		end
	end

	initial begin
		int          run_len;
		int          r;
		logic [15:0] d;
		logic [15:0] top;
		logic [15:0] ctrl_word;

		// Directed opening. Reset state first: the reload reads all ones.
		queue_item(MODE_READ, ADDR_ARR, 16'h0000);
		// Reload write without preload goes straight to the active reload.
		queue_item(MODE_WRITE, ADDR_ARR, 16'd2);
		queue_item(MODE_WRITE, ADDR_IRQEN, 16'hFFFF);
		queue_item(MODE_WRITE, ADDR_CTRL, 16'h0001);
		// Counts 0, 1, 2 and then wraps with an update event and the interrupt raised.
		repeat (3) queue_item(MODE_TICK, 3'd0, 16'h0000);
		queue_item(MODE_READ, ADDR_STAT, 16'h0000);
		queue_item(MODE_WRITE, ADDR_STAT, 16'h0000);
		// A counter above the reload wraps silently from its top to zero.
		queue_item(MODE_WRITE, ADDR_CNT, 16'hFFFF);
		queue_item(MODE_TICK, 3'd0, 16'hFFFF);
		// With updates disabled a forced update only clears the counts.
		queue_item(MODE_WRITE, ADDR_CTRL, 16'h008B);
		queue_item(MODE_WRITE, ADDR_EVENT, 16'h0001);
		// Update request source set: a forced update raises the event but not the flag.
		// The reload of zero sits in the preload until that update moves it over.
		queue_item(MODE_WRITE, ADDR_CTRL, 16'h008D);
		queue_item(MODE_WRITE, ADDR_ARR, 16'h0000);
		queue_item(MODE_WRITE, ADDR_EVENT, 16'hFFFF);
		// Zero reload: the counter does not move.
		queue_item(MODE_TICK, 3'd0, 16'h0000);
		// One-pulse: the wrap clears the enable, and the tick after it does nothing.
		queue_item(MODE_WRITE, ADDR_CTRL, 16'h0009);
		queue_item(MODE_WRITE, ADDR_ARR, 16'd1);
		repeat (3) queue_item(MODE_TICK, 3'd0, 16'h0000);
		queue_item(MODE_READ, ADDR_CTRL, 16'h0000);
		queue_item(MODE_WRITE, ADDR_PSC, 16'hFFFF);
		queue_item(MODE_READ, ADDR_PSC, 16'h0000);
		// The spare mode and the spare address do nothing and read as zero.
		queue_item(MODE_SPARE, ADDR_SPARE, 16'hFFFF);
		queue_item(MODE_WRITE, ADDR_SPARE, 16'hFFFF);
		queue_item(MODE_READ, ADDR_SPARE, 16'h0000);

		// Random part. Most segments set up a short prescaler and reload, start the counter and
		// then run mostly ticks with reads and pokes mixed in, so that overflows, one-pulse stops
		// and flag traffic are frequent. The rest are short stretches of arbitrary items.
		while (pending_items.size() < 1025) begin
			if ($urandom_range(0, 9) < 7) begin
				top = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 16'hFFFF))
					: 16'($urandom_range(0, 12));
				d = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 16'hFFFF))
					: 16'($urandom_range(0, 3));
				queue_item(MODE_WRITE, ADDR_PSC, d);
				queue_item(MODE_WRITE, ADDR_ARR, top);
				if ($urandom_range(0, 3) != 0)
					queue_item(MODE_WRITE, ADDR_CNT, 16'($urandom_range(0, top)));
				ctrl_word = 16'($urandom_range(0, 16'hFFFF));
				ctrl_word[CTRL_CEN_BIT] = ($urandom_range(0, 5) != 0);
				ctrl_word[CTRL_UDIS_BIT] = ($urandom_range(0, 5) == 0);
				queue_item(MODE_WRITE, ADDR_CTRL, ctrl_word);
				// A forced update moves preloaded values into the active copies.
				if ($urandom_range(0, 1) == 0)
					queue_item(MODE_WRITE, ADDR_EVENT, 16'($urandom_range(0, 16'hFFFF)));
				queue_item(MODE_WRITE, ADDR_IRQEN, 16'($urandom_range(0, 16'hFFFF)));
				// Used to restart the counter after a one-pulse stop.
				ctrl_word[CTRL_CEN_BIT] = 1'b1;
				run_len = $urandom_range(10, 40);
				repeat (run_len) begin
					r = $urandom_range(0, 19);
					d = 16'($urandom_range(0, 16'hFFFF));
					if (r < 14)
						queue_item(MODE_TICK, 3'($urandom_range(0, 7)), d);
					else if (r < 16)
						queue_item(MODE_READ, 3'($urandom_range(0, 7)), d);
					else if (r == 16)
						queue_item(MODE_WRITE, ADDR_STAT, d);
					else if (r == 17)
						queue_item(MODE_WRITE, ADDR_EVENT, d);
					else if (r == 18)
						queue_item(MODE_WRITE, ADDR_CTRL, ctrl_word);
					else
						queue_item(MODE_WRITE, ADDR_IRQEN, d);
				end
			end else begin
				run_len = $urandom_range(3, 12);
				repeat (run_len)
					queue_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
						16'($urandom_range(0, 16'hFFFF)));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent, everything owed has come back, then a few quiet cycles
		// in which any stray result would be caught by the monitor.
		while (pending_items.size() != 0 || in_valid || owed_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("tb_basic_update_timer_unit: PASS");
		end else begin
			$display("tb_basic_update_timer_unit: FAIL");
		end
		$finish;
	end

endmodule
